/* rtl/hpc_pkg.sv */
// Shared constants, types and arctangent table of the haversine proximity check
package hpc_pkg;

	localparam int ANGLE_FRAC_BITS = 24;
	localparam int CORDIC_STAGES = 24;
	localparam int CW = 34;
	localparam int KW = 5;
	localparam int SQ_STEPS = 31;
	localparam int SQ_RAD_W = 2 * SQ_STEPS;
	localparam int SQ_REM_W = SQ_STEPS + 2;
	localparam int DIST_W = 29;
	localparam int RAD_W = 23;
	localparam int IDX_W = 2;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [DIST_W-1:0] ALERT_RST = 29'd1600;
	localparam logic [RAD_W-1:0] RADIUS_RST = 23'd6371000;
	localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
	localparam logic [26:0] DEG_TO_RAD = 27'd74961321;

	typedef logic signed [CW-1:0] cw_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ALERT  = 2'd0,
		REG_RADIUS = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic v;
		cw_t x;
		cw_t y;
		cw_t z;
		logic [1:0] quad;
	} rot_t;

	typedef struct packed {
		logic v;
		cw_t x;
		cw_t y;
		cw_t z;
	} vec_t;

	typedef struct packed {
		logic v;
		logic [SQ_RAD_W-1:0] rad;
		logic [SQ_REM_W-1:0] rem;
		logic [SQ_STEPS-1:0] root;
	} sq_t;

	function automatic cw_t atan_q30(input logic [KW-1:0] k);
		cw_t r;
		case (k)
			5'd0:    r = 34'sh03243F6A8;
			5'd1:    r = 34'sh01DAC6705;
			5'd2:    r = 34'sh00FADBAFC;
			5'd3:    r = 34'sh007F56EA6;
			5'd4:    r = 34'sh003FEAB76;
			5'd5:    r = 34'sh001FFD55B;
			5'd6:    r = 34'sh000FFFAAA;
			5'd7:    r = 34'sh0007FFF55;
			5'd8:    r = 34'sh0003FFFEA;
			5'd9:    r = 34'sh0001FFFFD;
			5'd10:   r = 34'sh0000FFFFF;
			5'd11:   r = 34'sh00007FFFF;
			5'd12:   r = 34'sh00003FFFF;
			5'd13:   r = 34'sh00001FFFF;
			5'd14:   r = 34'sh00000FFFF;
			5'd15:   r = 34'sh000007FFF;
			5'd16:   r = 34'sh000003FFF;
			5'd17:   r = 34'sh000001FFF;
			5'd18:   r = 34'sh000000FFF;
			5'd19:   r = 34'sh0000007FF;
			5'd20:   r = 34'sh0000003FF;
			5'd21:   r = 34'sh0000001FF;
			5'd22:   r = 34'sh0000000FF;
			5'd23:   r = 34'sh00000007F;
			5'd24:   r = 34'sh00000003F;
			5'd25:   r = 34'sh00000001F;
			5'd26:   r = 34'sh00000000F;
			5'd27:   r = 34'sh000000008;
			5'd28:   r = 34'sh000000004;
			5'd29:   r = 34'sh000000002;
			5'd30:   r = 34'sh000000001;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/haversine_proximity_check.sv */
// Throughput: one beat per cycle; the output register stalls the whole cell chain when held.
// Rate is set by the slowest cell: one micro-rotation, one root digit or one 32x32 multiply.
// Reset: arst_n clears every valid bit and loads alert_distance 1600 and radius 6371000 m.
// Configuration writes are always ready; write only while no beat is in flight.
module haversine_proximity_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [31:0]            first_latitude,
	input  logic signed [32:0]            first_longitude,
	input  logic signed [31:0]            second_latitude,
	input  logic signed [32:0]            second_longitude,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hpc_pkg::DIST_W-1:0]    distance,
	output logic                          within_alert,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hpc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [hpc_pkg::DIST_W-1:0]    cfg_data
);

	localparam int FRAC = hpc_pkg::ANGLE_FRAC_BITS;
	localparam int NS = hpc_pkg::CORDIC_STAGES;
	localparam int NQ = hpc_pkg::SQ_STEPS;
	localparam int CW = hpc_pkg::CW;
	localparam int KW = hpc_pkg::KW;
	localparam int DW = hpc_pkg::DIST_W;
	localparam int RW = hpc_pkg::RAD_W;
	localparam int AW = 34;
	localparam int PW = RW + 33;

	logic adv;
	logic [DW-1:0] alert_q;
	logic [RW-1:0] radius_q;
	logic v_s1, v_s2, v_s3, v_m1, v_m2, v_m3, v_f1, v_f2, out_valid_q;
	logic signed [AW-1:0] ang_s1 [4];

	hpc_pkg::rot_t rot [4][NS+1];
	hpc_pkg::sq_t sq [2][NQ+1];
	hpc_pkg::vec_t vec [NS+1];
	hpc_pkg::cw_t sn [4];
	hpc_pkg::cw_t cs [4];
	logic [1:0] quad_end [4];

	hpc_pkg::cw_t p1_m1, p2_m1, p3_m1, p1_m2, p4_m2;
	logic signed [CW:0] a_sum;
	logic [30:0] a_m3, oma;
	logic [32:0] c_f1;
	logic [PW-1:0] prod_f2;
	logic [29:0] d_raw;
	logic [DW-1:0] d_sat, distance_q;
	logic within_q;

	function automatic hpc_pkg::cw_t mul30(input hpc_pkg::cw_t a, input hpc_pkg::cw_t b);
		logic signed [31:0] a32, b32;
		logic signed [63:0] pr;
		a32 = a[31:0];
		b32 = b[31:0];
		pr = a32 * b32;
		return CW'(pr >>> 30);
	endfunction

	assign adv = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_q <= hpc_pkg::ALERT_RST;
			radius_q <= hpc_pkg::RADIUS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == hpc_pkg::REG_ALERT) begin
				alert_q <= cfg_data;
			end else if (cfg_index == hpc_pkg::REG_RADIUS) begin
				radius_q <= cfg_data[RW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_m1 <= rot[0][NS].v & rot[1][NS].v & rot[2][NS].v & rot[3][NS].v;
			v_m2 <= v_m1;
			v_m3 <= v_m2;
			v_f1 <= vec[NS].v;
			v_f2 <= v_f1;
			out_valid_q <= v_f2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1[0] <= AW'(second_latitude) - AW'(first_latitude);
			ang_s1[1] <= AW'(second_longitude) - AW'(first_longitude);
			ang_s1[2] <= AW'(first_latitude);
			ang_s1[3] <= AW'(second_latitude);
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		localparam int K = (l < 2) ? FRAC + 4 : FRAC + 3;
		localparam int HW = AW - K;
		localparam int UW = HW + 6;
		localparam int S = UW + 7;
		localparam int RCW = S - 5;
		localparam longint RECIP = ((64'sd1 <<< S) + 44) / 45;

		logic signed [HW-1:0] h;
		logic [UW-1:0] u, qq;
		logic [UW+RCW-1:0] prod;
		logic [5:0] m, rhi;
		logic [7:0] t;
		logic [1:0] quad;
		logic [K+3:0] rem_s2;
		logic [1:0] quad_s2, quad_s3;
		logic [K+30:0] p_s3, pr;
		hpc_pkg::cw_t z0;

		always_comb begin
			h = ang_s1[l][AW-1:K];
			u = UW'(h) + UW'(45 << (HW - 1));
			prod = (UW+RCW)'(u) * (UW+RCW)'(RECIP);
			qq = UW'(prod >> S);
			m = 6'(u - qq * UW'(45));
			t = {m, ang_s1[l][K-1:K-2]};
			if (t >= 8'd135) begin
				quad = 2'd3;
				rhi = 6'(t - 8'd135);
			end else if (t >= 8'd90) begin
				quad = 2'd2;
				rhi = 6'(t - 8'd90);
			end else if (t >= 8'd45) begin
				quad = 2'd1;
				rhi = 6'(t - 8'd45);
			end else begin
				quad = 2'd0;
				rhi = t[5:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s2 <= {rhi, ang_s1[l][K-3:0]};
				quad_s2 <= quad;
				p_s3 <= (K+31)'(rem_s2) * (K+31)'(hpc_pkg::DEG_TO_RAD);
				quad_s3 <= quad_s2;
			end
		end

		assign pr = p_s3 + ((K+31)'(1) << (K - 2));
		assign z0 = CW'(pr[K+30:K-1]);
		assign rot[l][0] = '{v: v_s3, x: hpc_pkg::GAIN_INV, y: '0, z: z0, quad: quad_s3};

		for (genvar i = 0; i < NS; i++) begin : g_rot
			hpc_rot_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.k      (KW'(i)),
				.d      (rot[l][i]),
				.q      (rot[l][i+1])
			);
		end

		assign quad_end[l] = rot[l][NS].quad;

		always_comb begin
			case (quad_end[l])
				2'd0: begin
					sn[l] = rot[l][NS].y;
					cs[l] = rot[l][NS].x;
				end
				2'd1: begin
					sn[l] = rot[l][NS].x;
					cs[l] = -rot[l][NS].y;
				end
				2'd2: begin
					sn[l] = -rot[l][NS].y;
					cs[l] = -rot[l][NS].x;
				end
				default: begin
					sn[l] = -rot[l][NS].x;
					cs[l] = rot[l][NS].y;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_m1 <= mul30(sn[0], sn[0]);
			p2_m1 <= mul30(cs[2], cs[3]);
			p3_m1 <= mul30(sn[1], sn[1]);
			p1_m2 <= p1_m1;
			p4_m2 <= mul30(p2_m1, p3_m1);
			a_m3 <= a_sum[CW] ? '0 : (a_sum > (CW+1)'(1 <<< 30)) ? {1'b1, 30'd0} : a_sum[30:0];
		end
	end

	assign a_sum = (CW+1)'(p1_m2) + (CW+1)'(p4_m2);
	assign oma = {1'b1, 30'd0} - a_m3;

	assign sq[0][0] = '{v: v_m3, rad: {1'b0, a_m3, 30'd0}, rem: '0, root: '0};
	assign sq[1][0] = '{v: v_m3, rad: {1'b0, oma, 30'd0}, rem: '0, root: '0};

	for (genvar r = 0; r < 2; r++) begin : g_root
		for (genvar i = 0; i < NQ; i++) begin : g_dig
			hpc_sqrt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.d      (sq[r][i]),
				.q      (sq[r][i+1])
			);
		end
	end

	assign vec[0] = '{
		v: sq[0][NQ].v & sq[1][NQ].v,
		x: CW'(sq[1][NQ].root),
		y: CW'(sq[0][NQ].root),
		z: '0
	};

	for (genvar i = 0; i < NS; i++) begin : g_vec
		hpc_vec_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.k      (KW'(i)),
			.d      (vec[i]),
			.q      (vec[i+1])
		);
	end

	assign d_raw = prod_f2[PW-1:26];
	assign d_sat = d_raw[29] ? hpc_pkg::DIST_MAX : d_raw[DW-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			c_f1 <= vec[NS].z[CW-1] ? '0 : {vec[NS].z[31:0], 1'b0};
			prod_f2 <= PW'(radius_q) * PW'(c_f1) + (PW'(1) << 25);
			distance_q <= d_sat;
			within_q <= (d_sat <= alert_q);
		end
	end

	assign out_valid = out_valid_q;
	assign distance = distance_q;
	assign within_alert = within_q;

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_f2))
		else $error("result raised without a beat in the last stage");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(v_s1) && $stable(v_m3) && $stable(v_f2)))
		else $error("cell chain moved while the output was held");
	assert property (@(posedge clk) disable iff (!arst_n)
		vec[0].v |-> (sq[0][NQ].root <= {1'b1, 30'd0} && sq[1][NQ].root <= {1'b1, 30'd0}))
		else $error("square root beyond unity");
`endif

endmodule

/* rtl/hpc_rot_cell.sv */
// One rotation-mode CORDIC cell: a single micro-rotation towards zero angle
module hpc_rot_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [hpc_pkg::KW-1:0]   k,
	input  hpc_pkg::rot_t            d,
	output hpc_pkg::rot_t            q
);

	localparam int CW = hpc_pkg::CW;

	hpc_pkg::cw_t xs, ys, at, x_n, y_n, z_n;
	hpc_pkg::cw_t x_q, y_q, z_q;
	logic [1:0] quad_q;
	logic v_q;

	always_comb begin
		xs = d.x >>> k;
		ys = d.y >>> k;
		at = hpc_pkg::atan_q30(k);
		if (!d.z[CW-1]) begin
			x_n = d.x - ys;
			y_n = d.y + xs;
			z_n = d.z - at;
		end else begin
			x_n = d.x + ys;
			y_n = d.y - xs;
			z_n = d.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= d.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			quad_q <= d.quad;
		end
	end

	assign q = '{v: v_q, x: x_q, y: y_q, z: z_q, quad: quad_q};

endmodule

/* rtl/hpc_vec_cell.sv */
// One vectoring-mode CORDIC cell: a single micro-rotation towards the x axis
module hpc_vec_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [hpc_pkg::KW-1:0]   k,
	input  hpc_pkg::vec_t            d,
	output hpc_pkg::vec_t            q
);

	localparam int CW = hpc_pkg::CW;

	hpc_pkg::cw_t xs, ys, at, x_n, y_n, z_n;
	hpc_pkg::cw_t x_q, y_q, z_q;
	logic v_q;

	always_comb begin
		xs = d.x >>> k;
		ys = d.y >>> k;
		at = hpc_pkg::atan_q30(k);
		if (!d.y[CW-1]) begin
			x_n = d.x + ys;
			y_n = d.y - xs;
			z_n = d.z + at;
		end else begin
			x_n = d.x - ys;
			y_n = d.y + xs;
			z_n = d.z - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= d.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
	end

	assign q = '{v: v_q, x: x_q, y: y_q, z: z_q};

endmodule

/* rtl/hpc_sqrt_cell.sv */
// One digit of a restoring integer square root: two radicand bits in, one root bit out
module hpc_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  hpc_pkg::sq_t   d,
	output hpc_pkg::sq_t   q
);

	localparam int RDW = hpc_pkg::SQ_RAD_W;
	localparam int RMW = hpc_pkg::SQ_REM_W;
	localparam int NQ = hpc_pkg::SQ_STEPS;

	logic [RMW+1:0] cur, trial;
	logic [RMW-1:0] rem_n, rem_q;
	logic [NQ-1:0] root_n, root_q;
	logic [RDW-1:0] rad_q;
	logic v_q;

	always_comb begin
		cur = {d.rem, d.rad[RDW-1 -: 2]};
		trial = {2'b00, d.root, 2'b01};
		if (cur >= trial) begin
			rem_n = RMW'(cur - trial);
			root_n = {d.root[NQ-2:0], 1'b1};
		end else begin
			rem_n = RMW'(cur);
			root_n = {d.root[NQ-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= d.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q <= {d.rad[RDW-3:0], 2'b00};
			rem_q <= rem_n;
			root_q <= root_n;
		end
	end

	assign q = '{v: v_q, rad: rad_q, rem: rem_q, root: root_q};

endmodule

/* tb/sv/haversine_proximity_check_tb.sv */
// Self-checking testbench for the haversine proximity check: directed and random position pairs
module haversine_proximity_check_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [hpc_pkg::IDX_W-1:0] IDX_SPARE_A = 2'd2;
	localparam logic [hpc_pkg::IDX_W-1:0] IDX_SPARE_B = 2'd3;
	localparam longint LAT_SPAN = 64'sd1509949440;
	localparam longint LON_SPAN = 64'sd3019898880;
	localparam longint ARCTAN_Q30 [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	typedef struct {
		logic signed [31:0] lat1;
		logic signed [32:0] lon1;
		logic signed [31:0] lat2;
		logic signed [32:0] lon2;
	} pair_t;

	typedef struct {
		logic [hpc_pkg::DIST_W-1:0] gap;
		logic                       alert;
	} proximity_t;

	class proximity_scoreboard;
		logic [hpc_pkg::DIST_W-1:0] alert_dist = hpc_pkg::ALERT_RST;
		logic [hpc_pkg::RAD_W-1:0]  radius = hpc_pkg::RADIUS_RST;
		proximity_t                 pending[$];
		int                         errors = 0;
		int                         checked = 0;
		int                         alerts = 0;

		function void write_reg(logic [hpc_pkg::IDX_W-1:0] idx,
			logic [hpc_pkg::DIST_W-1:0] data);
			if (idx == hpc_pkg::REG_ALERT)
				alert_dist = data;
			else if (idx == hpc_pkg::REG_RADIUS)
				radius = data[hpc_pkg::RAD_W-1:0];
		endfunction

		function void sin_cos(longint ang, int frac, output longint sn, output longint cs);
			longint full, quarter, r, q, rem, z, x, y, xs, ys;
			longint unsigned p;
			full = longint'(360) << frac;
			quarter = longint'(90) << frac;
			r = ang % full;
			if (r < 0)
				r += full;
			q = r / quarter;
			rem = r - q * quarter;
			p = longint'(rem) * 74961321;
			z = longint'((p + (64'd1 << (frac + 1))) >> (frac + 2));
			x = 652032874;
			y = 0;
			for (int k = 0; k < hpc_pkg::CORDIC_STAGES; k++) begin
				xs = x >>> k;
				ys = y >>> k;
				if (z >= 0) begin
					x -= ys; y += xs; z -= ARCTAN_Q30[k];
				end else begin
					x += ys; y -= xs; z += ARCTAN_Q30[k];
				end
			end
			case (q & 3)
				0: begin sn = y; cs = x; end
				1: begin sn = x; cs = -y; end
				2: begin sn = -y; cs = -x; end
				default: begin sn = -x; cs = y; end
			endcase
		endfunction

		function longint arctan2(longint y, longint x);
			longint z, xs, ys;
			z = 0;
			for (int k = 0; k < hpc_pkg::CORDIC_STAGES; k++) begin
				xs = x >>> k;
				ys = y >>> k;
				if (y >= 0) begin
					x += ys; y -= xs; z += ARCTAN_Q30[k];
				end else begin
					x -= ys; y += xs; z -= ARCTAN_Q30[k];
				end
			end
			return z;
		endfunction

		function longint unsigned int_root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else
					res >>= 1;
				b >>= 2;
			end
			return res;
		endfunction

		function proximity_t great_circle(pair_t pr);
			longint sdl, cdl, sdo, cdo, s1, c1, s2, c2, a, ry, rx, c;
			longint unsigned d;
			proximity_t res;
			sin_cos(longint'(pr.lat2) - longint'(pr.lat1), hpc_pkg::ANGLE_FRAC_BITS + 1,
				sdl, cdl);
			sin_cos(longint'(pr.lon2) - longint'(pr.lon1), hpc_pkg::ANGLE_FRAC_BITS + 1,
				sdo, cdo);
			sin_cos(longint'(pr.lat1), hpc_pkg::ANGLE_FRAC_BITS, s1, c1);
			sin_cos(longint'(pr.lat2), hpc_pkg::ANGLE_FRAC_BITS, s2, c2);
			a = ((sdl * sdl) >>> 30) + ((((c1 * c2) >>> 30) * ((sdo * sdo) >>> 30)) >>> 30);
			if (a < 0)
				a = 0;
			if (a > (longint'(1) << 30))
				a = longint'(1) << 30;
			ry = longint'(int_root(longint'(a) << 30));
			rx = longint'(int_root(((longint'(1) << 30) - a) << 30));
			c = 2 * arctan2(ry, rx);
			if (c < 0)
				c = 0;
			d = (longint'(radius) * c + (64'd1 << 25)) >> 26;
			if (d > hpc_pkg::DIST_MAX)
				d = hpc_pkg::DIST_MAX;
			res.gap = d[hpc_pkg::DIST_W-1:0];
			res.alert = (d <= alert_dist);
			return res;
		endfunction

		function void note_pair(pair_t pr);
			pending.push_back(great_circle(pr));
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d, expected %0d", what, got, want);
			errors++;
		endtask

		task check_result(logic [hpc_pkg::DIST_W-1:0] got_gap, logic alert);
			proximity_t e;
			if (pending.size() == 0) begin
				report("unexpected beat, distance", got_gap, 0);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (alert)
				alerts++;
			if (got_gap !== e.gap)
				report("distance", got_gap, e.gap);
			if (alert !== e.alert)
				report("within_alert", alert, e.alert);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] first_latitude = '0;
	logic signed [32:0] first_longitude = '0;
	logic signed [31:0] second_latitude = '0;
	logic signed [32:0] second_longitude = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [hpc_pkg::DIST_W-1:0] distance;
	logic within_alert;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [hpc_pkg::IDX_W-1:0] cfg_index = '0;
	logic [hpc_pkg::DIST_W-1:0] cfg_data = '0;

	proximity_scoreboard sb = new();
	bit quiet = 0;
	bit hold_req = 0;
	int sent = 0;

	haversine_proximity_check dut (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#5ms;
		$display("[haversine_proximity_check] ERROR");
		$finish;
	end

	initial forever begin
		@(negedge clk);
		if (hold_req) begin
			hold_req = 0;
			repeat (300) begin
				out_stall = 1;
				@(negedge clk);
			end
		end
		out_stall = !quiet && ($urandom_range(99) < 37);
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(distance, within_alert);

	task send_pair(pair_t pr);
		while (!quiet && $urandom_range(99) < 37) begin
			@(negedge clk);
			in_valid = 0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid = 1;
		first_latitude = pr.lat1;
		first_longitude = pr.lon1;
		second_latitude = pr.lat2;
		second_longitude = pr.lon2;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_pair(pr);
		sent++;
	endtask

	task drain;
		@(negedge clk);
		in_valid = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task write_cfg(logic [hpc_pkg::IDX_W-1:0] idx, logic [hpc_pkg::DIST_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function pair_t mk(longint a, longint b, longint c, longint d);
		pair_t p;
		p.lat1 = a[31:0];
		p.lon1 = b[32:0];
		p.lat2 = c[31:0];
		p.lon2 = d[32:0];
		return p;
	endfunction

	function longint span_rand(longint h);
		return longint'({$urandom, $urandom} % (2 * h + 1)) - h;
	endfunction

	function pair_t rand_pair();
		pair_t p;
		int kind;
		kind = $urandom_range(99);
		if (kind < 20) begin
			p.lat1 = $urandom;
			p.lon1 = 33'({$urandom, $urandom});
			p.lat2 = $urandom;
			p.lon2 = 33'({$urandom, $urandom});
		end else begin
			p.lat1 = 32'(span_rand(LAT_SPAN));
			p.lon1 = 33'(span_rand(LON_SPAN));
			if (kind < 60) begin
				p.lat2 = 32'(p.lat1 + span_rand(longint'($urandom_range(1, 1 << 20))));
				p.lon2 = 33'(p.lon1 + span_rand(longint'($urandom_range(1, 1 << 20))));
			end else begin
				p.lat2 = 32'(span_rand(LAT_SPAN));
				p.lon2 = 33'(span_rand(LON_SPAN));
			end
		end
		return p;
	endfunction

	task random_phase(int n, bit hold_mid);
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2)
				hold_req = 1;
			send_pair(rand_pair());
		end
		drain();
	endtask

	initial begin
		pair_t pr;
		proximity_t pd;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (2) @(posedge clk);

		send_pair(mk(0, 0, 0, 0));
		send_pair(mk(0, 0, 0, 64'sd20000));
		send_pair(mk(0, 0, 0, LON_SPAN / 2));
		send_pair(mk(LAT_SPAN / 2, 0, -LAT_SPAN / 2, 0));
		send_pair(mk(LAT_SPAN, -LON_SPAN, -LAT_SPAN, LON_SPAN));
		send_pair(mk(-LAT_SPAN, LON_SPAN, LAT_SPAN, -LON_SPAN));
		send_pair(mk(32'h7FFFFFFF, 33'h0FFFFFFFF, 32'h80000000, 33'h100000000));
		send_pair(mk(32'h80000000, 33'h100000000, 32'h7FFFFFFF, 33'h0FFFFFFFF));
		send_pair(mk(-1, -1, 32'h7FFFFFFF, 33'h100000000));
		send_pair(mk(64'sd800000000, 64'sd100, 64'sd800001000, 64'sd200));
		drain();

		write_cfg(hpc_pkg::REG_ALERT, '0);
		write_cfg(hpc_pkg::REG_RADIUS, 29'd6000000);
		send_pair(mk(0, 0, 0, 0));
		send_pair(mk(100, 100, 101, 100));
		send_pair(mk(0, 0, 0, LON_SPAN / 2));
		drain();

		write_cfg(hpc_pkg::REG_ALERT, 29'd320241392);
		write_cfg(hpc_pkg::REG_RADIUS, 29'd7000000);
		send_pair(mk(0, 0, 0, LON_SPAN / 2));
		send_pair(mk(LAT_SPAN, 0, -LAT_SPAN, 0));
		drain();

		write_cfg(hpc_pkg::REG_ALERT, '1);
		write_cfg(hpc_pkg::REG_RADIUS, '1);
		write_cfg(IDX_SPARE_A, 29'd5);
		write_cfg(IDX_SPARE_B, '0);
		send_pair(mk(0, 0, 0, LON_SPAN / 2));
		send_pair(mk(32'h7FFFFFFF, 33'h0FFFFFFFF, 32'h80000000, 33'h100000000));
		drain();

		write_cfg(hpc_pkg::REG_RADIUS, 29'(hpc_pkg::RADIUS_RST));
		pr = mk(64'sd700000000, 64'sd1000000000, 64'sd700500000, 64'sd1000300000);
		pd = sb.great_circle(pr);
		write_cfg(hpc_pkg::REG_ALERT, pd.gap);
		send_pair(pr);
		drain();
		write_cfg(hpc_pkg::REG_ALERT, pd.gap - 29'd1);
		send_pair(pr);
		drain();

		write_cfg(hpc_pkg::REG_ALERT, hpc_pkg::ALERT_RST);
		random_phase(610, 1);

		write_cfg(hpc_pkg::REG_ALERT, 29'($urandom_range(0, 20000)));
		write_cfg(hpc_pkg::REG_RADIUS, 29'($urandom_range(6000000, 7000000)));
		quiet = 1;
		for (int i = 0; i < 250; i++)
			send_pair(rand_pair());
		quiet = 0;
		random_phase(360, 0);

		write_cfg(hpc_pkg::REG_ALERT, 29'($urandom_range(0, 320241392)));
		write_cfg(hpc_pkg::REG_RADIUS, 29'($urandom_range(6000000, 7000000)));
		random_phase(610, 0);

		if (sb.pending.size() != 0)
			sb.report("results still outstanding", 0, sb.pending.size());
		$display("covered %0d pairs, %0d results checked, %0d with alert raised",
			sent, sb.checked, sb.alerts);
		$display("configuration swept over alert 0..max and radius 6000000..max");
		if (sb.errors == 0)
			$display("[haversine_proximity_check] OK");
		else
			$display("[haversine_proximity_check] ERROR");
		$finish;
	end
endmodule

/* haversine_proximity_check.f */
rtl/hpc_pkg.sv
rtl/hpc_rot_cell.sv
rtl/hpc_vec_cell.sv
rtl/hpc_sqrt_cell.sv
rtl/haversine_proximity_check.sv
tb/sv/haversine_proximity_check_tb.sv
